// ===== rtl/core/tcce_pkg.sv =====
// Shared types, geometry and codes for the text console cursor engine.
package tcce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CELL_W  = 16;

	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h0F;

	localparam logic [1:0] MODE_PUT  = 2'd0;
	localparam logic [1:0] MODE_BACK = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [7:0]       char_code;
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_col;
	} item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_BACK,
		ST_SCROLL,
		ST_READ,
		ST_READ_DATA,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/core/text_console_cursor_engine_core.sv =====
// Top level of the text console cursor engine: sequencer, cursor and row base registers.
//
// After reset the block sweeps the 2000-cell screen memory to zero, one cell a
// cycle, and holds busy high while it does so; configuration writes are
// taken at any time. An item is taken when start is high and busy is low. A
// character put or backspace writes one cell; a newline, a backspace at home
// or an unused mode writes none, and a read off screen does not touch memory.
// A row wrap past the bottom also blanks the new bottom row:
// scrolling moves a row base register, so the one memory port only clears a
// single row. The result is shown on result for the one cycle that done is
// high and must be taken then; the block cannot be held off, and busy drops in
// that same cycle.
module text_console_cursor_engine_core
	import tcce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  item_t      in_item,
	output logic       busy,
	output logic       done,
	output result_t    result,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  row_q, base_q, base_inc, rr_q, sel_row;
	logic [COL_W-1:0]  col_q, cnt_q, rc_q, sel_col;
	logic [ADDR_W-1:0] clr_q, unit_addr, ram_addr;
	logic [7:0]        attr_q, char_q;
	logic [CELL_W-1:0] cell_q, ram_wdata, ram_rdata;
	logic              ram_en, ram_we, done_q, at_home, in_range;
	result_t           res_q;

	assign at_home  = (row_q == '0) && (col_q == '0);
	assign in_range = (in_item.read_row < ROW_W'(ROWS)) && (in_item.read_col < COL_W'(COLUMNS));
	assign base_inc = (base_q == ROW_LAST) ? '0 : base_q + 1'b1;

	tcce_addr_unit u_addr (
		.row  (sel_row),
		.col  (sel_col),
		.base (base_q),
		.addr (unit_addr)
	);

	assign ram_addr = (state_q == ST_CLEAR) ? clr_q : unit_addr;

	tcce_screen_ram u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = '0;
		sel_row   = row_q;
		sel_col   = col_q;
		case (state_q)
			ST_CLEAR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				if (clr_q == ADDR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (in_item.mode)
						MODE_PUT: begin
							if (in_item.char_code == NEWLINE_CODE) begin
								state_d = (row_q == ROW_LAST) ? ST_SCROLL : ST_FIN;
							end else begin
								state_d = ST_PUT;
							end
						end
						MODE_BACK: state_d = at_home ? ST_FIN : ST_BACK;
						MODE_READ: state_d = in_range ? ST_READ : ST_FIN;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_PUT: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = {attr_q, char_q};
				state_d   = ((col_q == COL_LAST) && (row_q == ROW_LAST)) ? ST_SCROLL : ST_FIN;
			end
			ST_BACK: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = {attr_q, BLANK_CODE};
				state_d   = ST_FIN;
			end
			ST_SCROLL: begin
				sel_row   = ROW_LAST;
				sel_col   = cnt_q;
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = {attr_q, BLANK_CODE};
				if (cnt_q == COL_LAST) state_d = ST_FIN;
			end
			ST_READ: begin
				sel_row = rr_q;
				sel_col = rc_q;
				ram_en  = 1'b1;
				state_d = ST_READ_DATA;
			end
			ST_READ_DATA: state_d = ST_FIN;
			ST_FIN:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
			cnt_q  <= '0;
			clr_q  <= '0;
			attr_q <= ATTR_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) attr_q <= cfg_wr_data;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (start) begin
						case (in_item.mode)
							MODE_PUT: begin
								if (in_item.char_code == NEWLINE_CODE) begin
									col_q <= '0;
									if (row_q == ROW_LAST) begin
										base_q <= base_inc;
										cnt_q  <= '0;
									end else begin
										row_q <= row_q + 1'b1;
									end
								end
							end
							MODE_BACK: begin
								if (!at_home) begin
									if (col_q != '0) begin
										col_q <= col_q - 1'b1;
									end else begin
										row_q <= row_q - 1'b1;
										col_q <= COL_LAST;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_PUT: begin
					if (col_q == COL_LAST) begin
						col_q <= '0;
						if (row_q == ROW_LAST) begin
							base_q <= base_inc;
							cnt_q  <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_SCROLL: cnt_q <= cnt_q + 1'b1;
				ST_FIN:    done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					char_q <= in_item.char_code;
					rr_q   <= in_item.read_row;
					rc_q   <= in_item.read_col;
					cell_q <= '0;
				end
			end
			ST_READ_DATA: cell_q <= ram_rdata;
			ST_FIN: begin
				res_q.cell_value <= cell_q;
				res_q.cursor_row <= row_q;
				res_q.cursor_col <= col_q;
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/core/tcce_screen_ram.sv =====
// Single-port screen cell memory with registered read data.
module tcce_screen_ram
	import tcce_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [CELL_W-1:0] wdata,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem_q [CELLS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== rtl/core/tcce_addr_unit.sv =====
// Shared address unit: maps a screen row and column to a memory address through the row base.
module tcce_addr_unit
	import tcce_pkg::*;
(
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  col,
	input  logic [ROW_W-1:0]  base,
	output logic [ADDR_W-1:0] addr
);

	localparam logic [ADDR_W-1:0] COLUMNS_A = ADDR_W'(COLUMNS);
	localparam logic [ROW_W:0]    ROWS_W    = (ROW_W + 1)'(ROWS);

	logic [ROW_W:0]   sum;
	logic [ROW_W-1:0] phys;

	always_comb begin
		sum  = {1'b0, row} + {1'b0, base};
		phys = (sum >= ROWS_W) ? ROW_W'(sum - ROWS_W) : sum[ROW_W-1:0];
		addr = ADDR_W'(ADDR_W'(phys) * COLUMNS_A) + ADDR_W'(col);
	end

endmodule
